FILE: src/rau_pkg.sv
// Package: shared types, constants and opcodes for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int W = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [W-1:0] a_num;
        logic signed [W-1:0] a_den;
        logic signed [W-1:0] b_num;
        logic signed [W-1:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [W-1:0] res_num;
        logic [W-2:0]        res_den;
        logic [1:0]          status;
    } out_item_t;

    // Classified operation handed from front to back
    typedef struct packed {
        logic        bad;
        logic [1:0]  op;
        logic        an_neg;
        logic        ad_neg;
        logic        bn_neg;
        logic        bd_neg;
        logic [W-1:0] an;
        logic [W-1:0] ad;
        logic [W-1:0] bn;
        logic [W-1:0] bd;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD_INIT, S_GCD, S_DIVN_INIT, S_DIVN,
        S_DIVD_INIT, S_DIVD, S_FIN, S_OUT
    } bstate_t;

endpackage

FILE: src/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit
// Exact add, subtract, multiply and divide on signed fractions, reduced by GCD.
// One item is in the back at a time, with one more held in the front. The back
// takes the item, forms the products and sets up (the product states, the combine
// state and the GCD setup), runs the Euclid steps (at most about 90 on 64-bit
// magnitudes) and leaves the loop, then runs the two final exact divisions
// (each a load and then its steps) and the range check. Each Euclid remainder
// and each exact division runs a one-bit-per-cycle restoring divider over 64
// bits. A zero operand denominator makes the back go straight from idle to the
// output state. The back returns to idle in the cycle after its result is popped.
`timescale 1ns / 1ps
module rational_arithmetic_unit_top #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::in_item_t  in_item,
    input  logic               push,
    output logic               full,
    output rau_pkg::out_item_t out_item,
    output logic               empty,
    input  logic               pop
);

    rau_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_take;

    rau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    rau_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .res(out_item), .empty(empty), .pop(pop)
    );

endmodule

FILE: src/rau_front.sv
// Front: accept items, split operands into sign and magnitude, flag zero denominators
`timescale 1ns / 1ps
module rau_front #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::in_item_t in_item,
    input  logic              push,
    output logic              full,
    output rau_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_take
);

    localparam int W = rau_pkg::W;

    rau_pkg::cmd_t cmd_reg, cmd_next;
    logic          valid_reg, valid_next;
    rau_pkg::cmd_t cls;

    // Magnitude of the low DATA_WIDTH bits, sign from bit DATA_WIDTH-1
    function automatic logic [W:0] smag(input logic [W-1:0] raw);
        logic [W-1:0] v;
        logic [W-1:0] m;
        begin
            v = raw & ((W'(1) << (DATA_WIDTH - 1) << 1) - W'(1));
            if (DATA_WIDTH == W)
            begin
                v = raw;
            end
            m = v;
            if (v[DATA_WIDTH-1])
            begin
                m = (~v + W'(1));
                if (DATA_WIDTH != W)
                begin
                    m = m & ((W'(1) << (DATA_WIDTH - 1) << 1) - W'(1));
                end
            end
            smag = {v[DATA_WIDTH-1], m};
        end
    endfunction

    // Classify the incoming transaction
    always_comb
    begin
        logic [W:0] an, ad, bn, bd;
        an = smag(in_item.a_num);
        ad = smag(in_item.a_den);
        bn = smag(in_item.b_num);
        bd = smag(in_item.b_den);
        cls.op     = in_item.op;
        cls.an_neg = an[W];
        cls.ad_neg = ad[W];
        cls.bn_neg = bn[W];
        cls.bd_neg = bd[W];
        cls.an     = an[W-1:0];
        cls.ad     = ad[W-1:0];
        cls.bn     = bn[W-1:0];
        cls.bd     = bd[W-1:0];
        cls.bad    = (ad[W-1:0] == '0) || (bd[W-1:0] == '0);
    end

    assign full = valid_reg;

    // Hold one classified command until the back takes it
    always_comb
    begin
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        if (cmd_take)
        begin
            valid_next = 1'b0;
        end
        if (push && !valid_reg)
        begin
            cmd_next   = cls;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

FILE: src/rau_back.sv
// Back: cross products, iterative GCD, two restoring divisions, range check
`timescale 1ns / 1ps
module rau_back #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output rau_pkg::out_item_t res,
    output logic               empty,
    input  logic               pop
);

    localparam int W  = rau_pkg::W;
    localparam int DW = 2 * W;
    localparam int CW = $clog2(DW + 1);

    rau_pkg::bstate_t state_reg, state_next;
    rau_pkg::cmd_t    c_reg;
    logic [DW-1:0] p0_reg, p1_reg, p2_reg;
    logic          p0n_reg, p1n_reg, p2n_reg;
    logic [DW-1:0] num_reg, den_reg;
    logic          numn_reg, denn_reg;
    logic [DW-1:0] x_reg, y_reg;
    logic [DW-1:0] q_reg, r_reg, dv_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] nm_reg;
    rau_pkg::out_item_t res_reg;

    logic [DW:0]   rtrial;
    logic [DW-1:0] rshift;
    logic [DW-1:0] half;
    logic          sum_neg;
    logic [DW-1:0] sum_mag;
    logic          neg;

    assign half = DW'(1) << (DATA_WIDTH - 1);

    // One restoring division step
    always_comb
    begin
        rshift = {r_reg[DW-2:0], q_reg[DW-1]};
        rtrial = {1'b0, rshift} - {1'b0, dv_reg};
    end

    // Signed sum of the two cross products
    always_comb
    begin
        if (p0n_reg == p1n_reg)
        begin
            sum_mag = p0_reg + p1_reg;
            sum_neg = p0n_reg;
        end
        else if (p0_reg >= p1_reg)
        begin
            sum_mag = p0_reg - p1_reg;
            sum_neg = p0n_reg;
        end
        else
        begin
            sum_mag = p1_reg - p0_reg;
            sum_neg = p1n_reg;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
    end

    assign neg = (nm_reg != '0) && (numn_reg != denn_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rau_pkg::S_IDLE:
                if (cmd_valid)
                begin
                    state_next = cmd.bad ? rau_pkg::S_OUT : rau_pkg::S_MUL1;
                end
            rau_pkg::S_MUL1:      state_next = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2:      state_next = rau_pkg::S_COMB;
            rau_pkg::S_COMB:      state_next = rau_pkg::S_GCD_INIT;
            rau_pkg::S_GCD_INIT:
                state_next = (den_reg == '0) ? rau_pkg::S_OUT : rau_pkg::S_GCD;
            rau_pkg::S_GCD:
                if (y_reg == '0 && cnt_reg == '0)
                begin
                    state_next = rau_pkg::S_DIVN_INIT;
                end
            rau_pkg::S_DIVN_INIT: state_next = rau_pkg::S_DIVN;
            rau_pkg::S_DIVN:
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = rau_pkg::S_DIVD_INIT;
                end
            rau_pkg::S_DIVD_INIT: state_next = rau_pkg::S_DIVD;
            rau_pkg::S_DIVD:
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = rau_pkg::S_FIN;
                end
            rau_pkg::S_FIN:       state_next = rau_pkg::S_OUT;
            rau_pkg::S_OUT:
                if (pop)
                begin
                    state_next = rau_pkg::S_IDLE;
                end
            default:              state_next = rau_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_take = 1'b0;
        empty    = 1'b1;
        case (state_reg)
            rau_pkg::S_IDLE: cmd_take = cmd_valid;
            rau_pkg::S_OUT:  empty    = 1'b0;
            default:
            begin
                cmd_take = 1'b0;
                empty    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: advance one step per state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rau_pkg::S_IDLE:
            begin
                c_reg <= cmd;
                if (cmd.bad)
                begin
                    res_reg <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_ZERO_DEN};
                end
            end
            rau_pkg::S_MUL1:
            begin
                // First pair of products
                if (c_reg.op == rau_pkg::OP_MUL)
                begin
                    p0_reg  <= DW'(c_reg.an) * DW'(c_reg.bn);
                    p0n_reg <= c_reg.an_neg ^ c_reg.bn_neg;
                end
                else
                begin
                    p0_reg  <= DW'(c_reg.an) * DW'(c_reg.bd);
                    p0n_reg <= c_reg.an_neg ^ c_reg.bd_neg;
                end
                if (c_reg.op == rau_pkg::OP_DIV)
                begin
                    p2_reg  <= DW'(c_reg.ad) * DW'(c_reg.bn);
                    p2n_reg <= c_reg.ad_neg ^ c_reg.bn_neg;
                end
                else
                begin
                    p2_reg  <= DW'(c_reg.ad) * DW'(c_reg.bd);
                    p2n_reg <= c_reg.ad_neg ^ c_reg.bd_neg;
                end
            end
            rau_pkg::S_MUL2:
            begin
                p1_reg  <= DW'(c_reg.bn) * DW'(c_reg.ad);
                p1n_reg <= c_reg.bn_neg ^ c_reg.ad_neg ^ (c_reg.op == rau_pkg::OP_SUB);
                if (p0_reg == '0)
                begin
                    p0n_reg <= 1'b0;
                end
                if (p2_reg == '0)
                begin
                    p2n_reg <= 1'b0;
                end
            end
            rau_pkg::S_COMB:
            begin
                if (c_reg.op == rau_pkg::OP_ADD || c_reg.op == rau_pkg::OP_SUB)
                begin
                    num_reg  <= sum_mag;
                    numn_reg <= sum_neg;
                end
                else
                begin
                    num_reg  <= p0_reg;
                    numn_reg <= p0n_reg;
                end
                den_reg  <= p2_reg;
                denn_reg <= p2n_reg;
            end
            rau_pkg::S_GCD_INIT:
            begin
                x_reg   <= num_reg;
                y_reg   <= den_reg;
                cnt_reg <= '0;
                if (den_reg == '0)
                begin
                    res_reg <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_ZERO_DEN};
                end
            end
            rau_pkg::S_GCD:
            begin
                // Euclid: x mod y by a restoring divider, then swap
                if (cnt_reg == '0)
                begin
                    if (y_reg != '0)
                    begin
                        q_reg   <= x_reg;
                        r_reg   <= '0;
                        dv_reg  <= y_reg;
                        cnt_reg <= CW'(1);
                    end
                end
                else
                begin
                    q_reg <= {q_reg[DW-2:0], ~rtrial[DW]};
                    r_reg <= rtrial[DW] ? rshift : rtrial[DW-1:0];
                    if (cnt_reg == CW'(DW))
                    begin
                        x_reg   <= y_reg;
                        y_reg   <= rtrial[DW] ? rshift : rtrial[DW-1:0];
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
            end
            rau_pkg::S_DIVN_INIT:
            begin
                q_reg   <= num_reg;
                r_reg   <= '0;
                dv_reg  <= x_reg;
                cnt_reg <= '0;
            end
            rau_pkg::S_DIVN, rau_pkg::S_DIVD:
            begin
                q_reg   <= {q_reg[DW-2:0], ~rtrial[DW]};
                r_reg   <= rtrial[DW] ? rshift : rtrial[DW-1:0];
                cnt_reg <= cnt_reg + CW'(1);
            end
            rau_pkg::S_DIVD_INIT:
            begin
                nm_reg  <= q_reg;
                q_reg   <= den_reg;
                r_reg   <= '0;
                cnt_reg <= '0;
            end
            rau_pkg::S_FIN:
            begin
                if (q_reg > half - DW'(1) || (neg ? nm_reg > half : nm_reg > half - DW'(1)))
                begin
                    res_reg <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_OVERFLOW};
                end
                else
                begin
                    res_reg.res_num <= neg ? W'((~nm_reg + DW'(1)) & ((half << 1) - DW'(1)))
                                           : W'(nm_reg);
                    res_reg.res_den <= (W-1)'(q_reg & (half - DW'(1)));
                    res_reg.status  <= rau_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

endmodule

FILE: src/rau_checker.sv
// Checker: port-level properties of the rational arithmetic unit
`timescale 1ns / 1ps
module rau_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input rau_pkg::out_item_t out_item
);

    // A waiting result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while waiting");

    // Error results carry zero fields
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.status != rau_pkg::ST_OK) |->
        (out_item.res_num == '0 && out_item.res_den == '0))
        else $error("error result not zeroed");

    // A good result has nonzero denominator
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.status == rau_pkg::ST_OK) |-> (out_item.res_den != '0))
        else $error("zero denominator with ok status");

    // Status never takes the unused code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.status == rau_pkg::ST_OK
                    || out_item.status == rau_pkg::ST_ZERO_DEN
                    || out_item.status == rau_pkg::ST_OVERFLOW))
        else $error("bad status code");

    // An accepted transaction occupies the input slot
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("input slot not held after accept");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty),
    .pop(pop), .out_item(out_item)
);

FILE: test/tb_rational_arithmetic_unit_top.sv
// Testbench for the rational arithmetic unit: directed and random fractions checked in order
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit_top;

    typedef struct {
        bit              neg;
        longint unsigned mag;
    } sfrac_t;

    localparam longint unsigned HALF_RANGE = 64'h8000_0000;

    // Split a 32-bit two's complement value into sign and magnitude
    function automatic sfrac_t split_sign(logic [rau_pkg::W-1:0] v);
        sfrac_t s;
        s.neg = v[rau_pkg::W-1];
        s.mag = v[rau_pkg::W-1] ? ({32'b0, ~v} + 64'd1) : {32'b0, v};
        return s;
    endfunction

    function automatic sfrac_t signed_mul(sfrac_t x, sfrac_t y);
        sfrac_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic sfrac_t signed_add(sfrac_t x, sfrac_t y);
        sfrac_t r;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end
        else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end
        else begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0)
            r.neg = 0;
        return r;
    endfunction

    // Compute the reduced fraction and status for one operation
    function automatic rau_pkg::out_item_t reduced_fraction(rau_pkg::in_item_t it);
        sfrac_t an, ad, bn, bd, num, den;
        longint unsigned g, t, x, nm, dm;
        bit neg;
        rau_pkg::out_item_t r;
        r = '0;
        an = split_sign(it.a_num);
        ad = split_sign(it.a_den);
        bn = split_sign(it.b_num);
        bd = split_sign(it.b_den);
        if (ad.mag == 0 || bd.mag == 0) begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        case (rau_pkg::op_t'(it.op))
            rau_pkg::OP_ADD:
            begin
                num = signed_add(signed_mul(an, bd), signed_mul(bn, ad));
                den = signed_mul(ad, bd);
            end
            rau_pkg::OP_SUB:
            begin
                bn.neg = !bn.neg;
                num = signed_add(signed_mul(an, bd), signed_mul(bn, ad));
                den = signed_mul(ad, bd);
            end
            rau_pkg::OP_MUL:
            begin
                num = signed_mul(an, bn);
                den = signed_mul(ad, bd);
            end
            default:
            begin
                num = signed_mul(an, bd);
                den = signed_mul(ad, bn);
            end
        endcase
        if (den.mag == 0) begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        // Euclid on the magnitudes
        x = num.mag;
        g = den.mag;
        while (g != 0) begin
            t = x % g;
            x = g;
            g = t;
        end
        nm = num.mag / x;
        dm = den.mag / x;
        neg = (nm != 0) && (num.neg != den.neg);
        if (dm > HALF_RANGE - 1 || (neg ? nm > HALF_RANGE : nm > HALF_RANGE - 1)) begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.res_num = neg ? rau_pkg::W'(-nm) : rau_pkg::W'(nm);
        r.res_den = dm[rau_pkg::W-2:0];
        r.status  = rau_pkg::ST_OK;
        return r;
    endfunction

    class fraction_scoreboard;
        rau_pkg::out_item_t pending[$];
        int                 mismatches;

        function void note_input(rau_pkg::in_item_t it);
            pending.push_back(reduced_fraction(it));
        endfunction

        function void check_result(rau_pkg::out_item_t got);
            rau_pkg::out_item_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result num=%0d den=%0d status=%0d",
                             got.res_num, got.res_den, got.status);
                return;
            end
            want = pending.pop_front();
            if (got.res_num !== want.res_num || got.res_den !== want.res_den
                || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                             want.res_num, want.res_den, want.status,
                             got.res_num, got.res_den, got.status);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    rau_pkg::in_item_t  in_item;
    logic               push;
    logic               full;
    rau_pkg::out_item_t out_item;
    logic               empty;
    logic               pop;

    fraction_scoreboard sb;
    int  results_seen;
    int  items_sent;

    rational_arithmetic_unit_top DUT (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
        .out_item(out_item), .empty(empty), .pop(pop)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung run
    initial begin
        #400_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Offer one transaction and hold it until accepted
    task automatic send_fraction(rau_pkg::in_item_t it);
        bit quiet;
        quiet = (items_sent >= 400 && items_sent < 600);
        while (!quiet && $urandom_range(99) < 8) begin
            @(negedge clk);
            push = 0;
        end
        @(negedge clk);
        push    = 1;
        in_item = it;
        do @(posedge clk); while (full);
        sb.note_input(it);
        items_sent++;
        @(negedge clk);
        push = 0;
    endtask

    task automatic send_op(rau_pkg::op_t op, int an, int ad, int bn, int bd);
        rau_pkg::in_item_t it;
        it.op = op; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
        send_fraction(it);
    endtask

    // Mostly small values, some full-width, some extremes
    function automatic logic [rau_pkg::W-1:0] pick_value(bit nonzero);
        logic [rau_pkg::W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = rau_pkg::W'($signed($urandom_range(40)) - 20);
            4, 5:       v = rau_pkg::W'($signed($urandom_range(2000)) - 1000);
            6, 7:       v = $urandom;
            8:          v = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default:    v = $urandom_range(1) ? 32'hffff_ffff : 32'd1;
        endcase
        if (nonzero && v == 0)
            v = 1;
        return v;
    endfunction

    // Receiver: random pops plus one long hold-off
    initial begin
        bit held;
        held = 0;
        pop = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && results_seen == 150) begin
                held = 1;
                pop = 0;
                repeat (20000) @(negedge clk);
            end
            pop = (results_seen >= 400 && results_seen < 600) || ($urandom_range(99) >= 8);
            @(posedge clk);
            if (pop && !empty) begin
                sb.check_result(out_item);
                results_seen++;
            end
        end
    end

    initial begin
        rau_pkg::in_item_t it;
        int wait_cycles;
        sb = new();
        results_seen = 0;
        items_sent = 0;
        push = 0;
        in_item = '0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, every operation, special cases
        send_op(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_op(rau_pkg::OP_SUB, 1, 2, 1, 3);
        send_op(rau_pkg::OP_MUL, -3, 4, 2, 9);
        send_op(rau_pkg::OP_DIV, 3, 4, -3, 8);
        send_op(rau_pkg::OP_ADD, 5, 0, 1, 1);
        send_op(rau_pkg::OP_MUL, 5, 1, 1, 0);
        send_op(rau_pkg::OP_DIV, 7, 3, 0, 5);
        send_op(rau_pkg::OP_SUB, 2, 3, 2, 3);
        send_op(rau_pkg::OP_MUL, 0, -7, 9, 4);
        send_op(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_op(rau_pkg::OP_SUB, 32'h8000_0000, 1, 1, 1);
        send_op(rau_pkg::OP_MUL, 32'h8000_0000, 1, -1, 1);
        send_op(rau_pkg::OP_MUL, 32'h8000_0000, 1, 1, 1);
        send_op(rau_pkg::OP_DIV, 1, 32'h7fff_ffff, 1, 32'h7fff_ffff);
        send_op(rau_pkg::OP_MUL, 1, 32'h7fff_ffff, 1, 2);
        send_op(rau_pkg::OP_ADD, 3, -4, 1, -4);
        send_op(rau_pkg::OP_MUL, -3, -5, -2, -7);
        send_op(rau_pkg::OP_SUB, 4, 1, 1, 3);
        send_op(rau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, -1, -1);
        send_op(rau_pkg::OP_DIV, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'hffff_ffff);
        send_op(rau_pkg::OP_ADD, 0, 1, 0, 32'h8000_0000);

        // Random transactions
        repeat (1180) begin
            it.op    = 2'($urandom_range(3));
            it.a_num = pick_value(0);
            it.b_num = pick_value($urandom_range(19) != 0);
            it.a_den = $urandom_range(24) == 0 ? 0 : pick_value(1);
            it.b_den = $urandom_range(24) == 0 ? 0 : pick_value(1);
            send_fraction(it);
        end

        // Drain, then watch for stray results
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 2_000_000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (7000) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: filelist.f
src/rau_pkg.sv
src/rau_front.sv
src/rau_back.sv
src/rational_arithmetic_unit_top.sv
src/rau_checker.sv
test/tb_rational_arithmetic_unit_top.sv
